### hdl/spfs_pkg.sv
// Shared constants, opcode codes and types for the fetch stage.
package spfs_pkg;

    // Width of the program counter and of truncated branch targets.
    localparam int ADDR_BITS = 16;

    // Fixed field widths of the stream payloads.
    localparam int OPCODE_BITS  = 6;
    localparam int OPERAND_BITS = 32;
    localparam int PCOUT_BITS   = 16;
    localparam int ALT_BITS     = 17;
    localparam int PLEN_BITS    = 16;

    // Width used to compare the pc against the program length.
    localparam int CMP_BITS = (ADDR_BITS > PLEN_BITS) ? ADDR_BITS : PLEN_BITS;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_FIELD_BITS  = OPCODE_BITS + 3 * OPERAND_BITS + PCOUT_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = OPCODE_BITS + 3 * OPERAND_BITS + 1 + ALT_BITS
                                    + 2 * PCOUT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 3;
    localparam logic CFG_IDX_PROGRAM_LENGTH = 1'b0;
    localparam logic CFG_IDX_PREDICT_TAKEN  = 1'b1;

    // Item kinds carried on the input tuser.
    localparam logic KIND_FETCH    = 1'b0;
    localparam logic KIND_REDIRECT = 1'b1;

    // Branch opcodes.
    localparam logic [OPCODE_BITS-1:0] OP_BEQ  = 6'd10;
    localparam logic [OPCODE_BITS-1:0] OP_BNE  = 6'd11;
    localparam logic [OPCODE_BITS-1:0] OP_BGEZ = 6'd12;
    localparam logic [OPCODE_BITS-1:0] OP_BGTZ = 6'd13;
    localparam logic [OPCODE_BITS-1:0] OP_BLEZ = 6'd14;
    localparam logic [OPCODE_BITS-1:0] OP_BLTZ = 6'd15;
    localparam logic [OPCODE_BITS-1:0] OP_J    = 6'd16;
    localparam logic [OPCODE_BITS-1:0] OP_JR   = 6'd17;

    // Recovery address meaning "no alternative path".
    localparam logic [ALT_BITS-1:0] ALT_NONE = '1;

    // Decoded branch information for one instruction.
    typedef struct packed {
        logic                 is_branch;
        logic                 is_jr;
        logic [ADDR_BITS-1:0] target;
    } branch_info_t;

    // One result transaction before packing.
    typedef struct packed {
        logic                    fetched;
        logic [OPCODE_BITS-1:0]  opcode;
        logic [OPERAND_BITS-1:0] operand_zero;
        logic [OPERAND_BITS-1:0] operand_one;
        logic [OPERAND_BITS-1:0] operand_two;
        logic                    is_branch;
        logic [ALT_BITS-1:0]     alternative_address;
        logic [PCOUT_BITS-1:0]   fetch_address;
        logic [PCOUT_BITS-1:0]   next_pc;
    } fetch_result_t;

endpackage

### hdl/spfs_decode.sv
// Branch decoder: classifies the opcode and selects the truncated target.
module spfs_decode
    import spfs_pkg::*;
(
    input  logic [OPCODE_BITS-1:0]  opcode,
    input  logic [OPERAND_BITS-1:0] operand_zero,
    input  logic [OPERAND_BITS-1:0] operand_one,
    input  logic [OPERAND_BITS-1:0] operand_two,
    output branch_info_t            info
);

    logic [OPERAND_BITS-1:0] target_full;

    // Pick the operand that holds the target for this opcode.
    always_comb
    begin
        info.is_branch = 1'b0;
        info.is_jr     = 1'b0;
        target_full    = operand_one;
        unique case (opcode)
            OP_BEQ, OP_BNE:
            begin
                info.is_branch = 1'b1;
                target_full    = operand_two;
            end
            OP_BGEZ, OP_BGTZ, OP_BLEZ, OP_BLTZ:
            begin
                info.is_branch = 1'b1;
                target_full    = operand_one;
            end
            OP_J:
            begin
                info.is_branch = 1'b1;
                target_full    = operand_zero;
            end
            OP_JR:
            begin
                info.is_branch = 1'b1;
                info.is_jr     = 1'b1;
            end
            default:
            begin
                info.is_branch = 1'b0;
            end
        endcase
        info.target = target_full[ADDR_BITS-1:0];
    end

endmodule

### hdl/static_predict_fetch_stage_top.sv
// Top level of the fetch stage with static branch prediction.
// The result of an accepted input transaction is registered and appears on the output in the next cycle.
// Throughput: one transaction per cycle while the output is not stalled; the pc update and the result are computed
// by one mux-and-increment path into the output register.
// Reset (rst_n, asynchronous, active low) clears the pc, both configuration
// registers and the output valid flag.
module static_predict_fetch_stage_top
    import spfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input stream.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata from bit 0: opcode[5:0], operand_zero[37:6], operand_one[69:38],
    // operand_two[101:70], new_pc[117:102], zero padding[119:118]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: kind (0 fetch, 1 redirect)
    input  logic                     s_axis_tuser,
    // Output stream.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata from bit 0: out_opcode[5:0], out_operand_zero[37:6],
    // out_operand_one[69:38], out_operand_two[101:70], is_branch[102],
    // alternative_address[119:103], fetch_address[135:120], next_pc[151:136]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // tuser: fetched
    output logic                     m_axis_tuser,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [PLEN_BITS-1:0]    program_length_reg;
    logic                    predict_taken_reg;
    logic [ADDR_BITS-1:0]    pc_reg;
    logic [ADDR_BITS-1:0]    pc_next;
    logic                    out_valid_reg;
    fetch_result_t           result_reg;
    fetch_result_t           result_next;
    branch_info_t            br_info;
    logic                    in_accept;
    logic                    cfg_write;
    logic                    cfg_idx;
    logic [OPCODE_BITS-1:0]  in_opcode;
    logic [OPERAND_BITS-1:0] in_operand_zero;
    logic [OPERAND_BITS-1:0] in_operand_one;
    logic [OPERAND_BITS-1:0] in_operand_two;
    logic [PCOUT_BITS-1:0]   in_new_pc;
    logic [ADDR_BITS-1:0]    pc_inc;
    logic                    pc_in_range;

    // Unpack the input transaction.
    assign in_opcode       = s_axis_tdata[OPCODE_BITS-1:0];
    assign in_operand_zero = s_axis_tdata[OPCODE_BITS +: OPERAND_BITS];
    assign in_operand_one  = s_axis_tdata[OPCODE_BITS + OPERAND_BITS +: OPERAND_BITS];
    assign in_operand_two  = s_axis_tdata[OPCODE_BITS + 2 * OPERAND_BITS +: OPERAND_BITS];
    assign in_new_pc       = s_axis_tdata[OPCODE_BITS + 3 * OPERAND_BITS +: PCOUT_BITS];

    // The output register frees up whenever its transaction is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    spfs_decode u_decode (
        .opcode       (in_opcode),
        .operand_zero (in_operand_zero),
        .operand_one  (in_operand_one),
        .operand_two  (in_operand_two),
        .info         (br_info)
    );

    assign pc_inc      = pc_reg + ADDR_BITS'(1);
    assign pc_in_range = CMP_BITS'(pc_reg) < CMP_BITS'(program_length_reg);

    // Next pc and result for the transaction at the input.
    always_comb
    begin
        result_next                     = '0;
        result_next.alternative_address = ALT_NONE;
        pc_next                         = pc_reg;
        if (s_axis_tuser == KIND_REDIRECT)
        begin
            pc_next = ADDR_BITS'(in_new_pc);
        end
        else if (pc_in_range)
        begin
            pc_next = pc_inc;
            if (br_info.is_branch)
            begin
                if (predict_taken_reg)
                begin
                    result_next.alternative_address = ALT_BITS'(pc_inc);
                    pc_next = br_info.is_jr ? pc_reg : br_info.target;
                end
                else if (!br_info.is_jr)
                begin
                    result_next.alternative_address = ALT_BITS'(br_info.target);
                end
            end
            result_next.fetched       = 1'b1;
            result_next.opcode        = in_opcode;
            result_next.operand_zero  = in_operand_zero;
            result_next.operand_one   = in_operand_one;
            result_next.operand_two   = in_operand_two;
            result_next.is_branch     = br_info.is_branch;
            result_next.fetch_address = PCOUT_BITS'(pc_reg);
        end
        result_next.next_pc = PCOUT_BITS'(pc_next);
    end

    // Pc and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                pc_reg <= pc_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    // Pack the result transaction.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.fetched;
    assign m_axis_tdata  = OUT_DATA_BITS'({result_reg.next_pc,
                                          result_reg.fetch_address,
                                          result_reg.alternative_address,
                                          result_reg.is_branch,
                                          result_reg.operand_two,
                                          result_reg.operand_one,
                                          result_reg.operand_zero,
                                          result_reg.opcode});

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= '0;
            predict_taken_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                CFG_IDX_PROGRAM_LENGTH: program_length_reg <= pwdata[PLEN_BITS-1:0];
                CFG_IDX_PREDICT_TAKEN:  predict_taken_reg  <= pwdata[0];
                default:                predict_taken_reg  <= predict_taken_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            CFG_IDX_PROGRAM_LENGTH: prdata = 32'(program_length_reg);
            CFG_IDX_PREDICT_TAKEN:  prdata = 32'(predict_taken_reg);
            default:                prdata = '0;
        endcase
    end

endmodule

### tb/static_predict_fetch_stage_checker.sv
// Checker for the fetch stage: tracks configuration, predicts each result and compares it.
`timescale 1ns / 100ps

module static_predict_fetch_stage_checker
    import spfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    // tdata from bit 0: opcode, operand_zero, operand_one, operand_two, new_pc, padding
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic                     s_axis_tuser,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata from bit 0: out_opcode, out_operand_zero, out_operand_one,
    // out_operand_two, is_branch, alternative_address, fetch_address, next_pc
    input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // tuser: fetched
    input  logic                     m_axis_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    output int                       error_count,
    output int                       pending_count,
    output int                       result_count,
    output int                       fetch_count
);

    // Shadow copies of the pc and the two configuration registers.
    logic [ADDR_BITS-1:0] pc_shadow;
    logic [PLEN_BITS-1:0] length_shadow;
    logic                 taken_shadow;

    // Results still owed by the block, oldest first.
    fetch_result_t owed_results[$];

    // Works out the result of one item from the current pc and configuration.
    function automatic fetch_result_t fetch_outcome(input logic kind,
                                                    input logic [OPCODE_BITS-1:0] op,
                                                    input logic [OPERAND_BITS-1:0] opnd0,
                                                    input logic [OPERAND_BITS-1:0] opnd1,
                                                    input logic [OPERAND_BITS-1:0] opnd2,
                                                    input logic [PCOUT_BITS-1:0] jump_pc);
        fetch_result_t        res;
        logic                 branch;
        logic [ADDR_BITS-1:0] target;
        logic [ADDR_BITS-1:0] incremented;
        logic [ADDR_BITS-1:0] upcoming;
        logic [ALT_BITS-1:0]  recovery;
        res = '0;
        res.alternative_address = ALT_NONE;
        if (kind == KIND_REDIRECT)
        begin
            res.next_pc = jump_pc;
            return res;
        end
        // Past the end of the program nothing is fetched and the pc holds.
        if (pc_shadow >= length_shadow)
        begin
            res.next_pc = pc_shadow;
            return res;
        end
        branch = (op >= OP_BEQ) && (op <= OP_JR);
        case (op)
            OP_BEQ, OP_BNE: target = opnd2[ADDR_BITS-1:0];
            OP_J:           target = opnd0[ADDR_BITS-1:0];
            default:        target = opnd1[ADDR_BITS-1:0];
        endcase
        incremented = pc_shadow + ADDR_BITS'(1);
        upcoming    = incremented;
        recovery    = ALT_NONE;
        if (branch)
        begin
            if (taken_shadow)
            begin
                // Taken: follow the target (JR holds the pc), recover at the next sequential address.
                recovery = {1'b0, incremented};
                upcoming = (op == OP_JR) ? pc_shadow : target;
            end
            else if (op != OP_JR)
            begin
                recovery = {1'b0, target};
            end
        end
        res.fetched             = 1'b1;
        res.opcode              = op;
        res.operand_zero        = opnd0;
        res.operand_one         = opnd1;
        res.operand_two         = opnd2;
        res.is_branch           = branch;
        res.alternative_address = recovery;
        res.fetch_address       = pc_shadow;
        res.next_pc             = upcoming;
        return res;
    endfunction

    // Counts one mismatching field and reports the first few.
    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            if (error_count < 10)
                $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field,
                         want, got);
            error_count++;
        end
    endtask

    // Register writes, result comparison and prediction, in that order per edge.
    always @(posedge clk or negedge rst_n)
    begin
        fetch_result_t want;
        fetch_result_t got;
        if (!rst_n)
        begin
            pc_shadow     = '0;
            length_shadow = '0;
            taken_shadow  = 1'b0;
            owed_results.delete();
            error_count   = 0;
            result_count  = 0;
            fetch_count   = 0;
        end
        else
        begin
            // Configuration write at the access phase.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == CFG_IDX_PROGRAM_LENGTH)
                    length_shadow = pwdata[PLEN_BITS-1:0];
                else if (paddr[2] == CFG_IDX_PREDICT_TAKEN)
                    taken_shadow = pwdata[0];
            end

            // Result transaction against the oldest expectation.
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (owed_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: result transaction with nothing expected", $realtime);
                    error_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    got.fetched             = m_axis_tuser;
                    got.opcode              = m_axis_tdata[5:0];
                    got.operand_zero        = m_axis_tdata[37:6];
                    got.operand_one         = m_axis_tdata[69:38];
                    got.operand_two         = m_axis_tdata[101:70];
                    got.is_branch           = m_axis_tdata[102];
                    got.alternative_address = m_axis_tdata[119:103];
                    got.fetch_address       = m_axis_tdata[135:120];
                    got.next_pc             = m_axis_tdata[151:136];
                    if (got.fetched)
                        fetch_count++;
                    flag_field("fetched", 32'(want.fetched), 32'(got.fetched));
                    flag_field("opcode", 32'(want.opcode), 32'(got.opcode));
                    flag_field("operand_zero", want.operand_zero, got.operand_zero);
                    flag_field("operand_one", want.operand_one, got.operand_one);
                    flag_field("operand_two", want.operand_two, got.operand_two);
                    flag_field("is_branch", 32'(want.is_branch), 32'(got.is_branch));
                    flag_field("alternative_address", 32'(want.alternative_address),
                               32'(got.alternative_address));
                    flag_field("fetch_address", 32'(want.fetch_address),
                               32'(got.fetch_address));
                    flag_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
                end
            end

            // Input transaction: predict and advance the shadow pc.
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = fetch_outcome(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
                                     s_axis_tdata[69:38], s_axis_tdata[101:70],
                                     s_axis_tdata[117:102]);
                owed_results.push_back(want);
                pc_shadow = want.next_pc;
            end
        end
        pending_count = owed_results.size();
    end

endmodule

### tb/static_predict_fetch_stage_top_test.sv
// Testbench top for the fetch stage: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module static_predict_fetch_stage_top_test;
    import spfs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // tdata from bit 0: opcode, operand_zero, operand_one, operand_two, new_pc, padding
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    // tuser: kind
    logic                     s_axis_tuser = KIND_FETCH;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // tdata from bit 0: out_opcode, out_operand_zero, out_operand_one,
    // out_operand_two, is_branch, alternative_address, fetch_address, next_pc
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    // tuser: fetched
    logic                     m_axis_tuser;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int error_count;
    int pending_count;
    int result_count;
    int fetch_count;

    // Stimulus bookkeeping.
    logic        steady = 1'b0;
    int unsigned length_now = 0;
    int          sent_count = 0;
    int          setting_count = 0;
    int          cycle_count = 0;

    static_predict_fetch_stage_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    static_predict_fetch_stage_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .fetch_count   (fetch_count)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side back-pressure, off during the steady stretch.
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 36);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("static_predict_fetch_stage_top_test: errors");
            $finish;
        end
    end

    // Drives one input transaction, with random gaps ahead of it; entered at a falling edge.
    task automatic send_item(input logic kind, input logic [OPCODE_BITS-1:0] op,
                             input logic [OPERAND_BITS-1:0] opnd0,
                             input logic [OPERAND_BITS-1:0] opnd1,
                             input logic [OPERAND_BITS-1:0] opnd2,
                             input logic [PCOUT_BITS-1:0] jump_pc);
        while (!steady && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, jump_pc, opnd2, opnd1, opnd0, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // Writes one configuration register through the setup and access phases.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops the input stream and waits until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Drains, then loads a new program length and prediction mode.
    task automatic reconfigure(input int unsigned plen, input logic taken);
        drain();
        write_reg(CFG_IDX_PROGRAM_LENGTH, plen);
        write_reg(CFG_IDX_PREDICT_TAKEN, {31'd0, taken});
        length_now = plen;
        setting_count++;
    endtask

    // One random item: mostly fetches, many of them branches, some redirects and noise.
    task automatic random_item();
        logic                    kind;
        logic [OPCODE_BITS-1:0]  op;
        logic [OPERAND_BITS-1:0] opnd0;
        logic [OPERAND_BITS-1:0] opnd1;
        logic [OPERAND_BITS-1:0] opnd2;
        logic [PCOUT_BITS-1:0]   jump_pc;
        kind = ($urandom_range(99) < 10) ? KIND_REDIRECT : KIND_FETCH;
        if ($urandom_range(1))
            op = OP_BEQ + OPCODE_BITS'($urandom_range(7));
        else
            op = OPCODE_BITS'($urandom_range(63));
        opnd0 = $urandom;
        opnd1 = $urandom;
        opnd2 = $urandom;
        // Keep many targets inside the program so taken branches keep fetching.
        if (length_now > 0)
        begin
            if ($urandom_range(1))
                opnd0[15:0] = 16'($urandom_range(length_now - 1));
            if ($urandom_range(1))
                opnd1[15:0] = 16'($urandom_range(length_now - 1));
            if ($urandom_range(1))
                opnd2[15:0] = 16'($urandom_range(length_now - 1));
        end
        if ($urandom_range(99) < 80)
            jump_pc = PCOUT_BITS'($urandom_range(length_now));
        else
            jump_pc = PCOUT_BITS'($urandom);
        send_item(kind, op, opnd0, opnd1, opnd2, jump_pc);
    endtask

    initial
    begin
        int          k;
        int unsigned plen;
        logic        taken;
        int          count;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: a zero program length fetches nothing.
        send_item(KIND_FETCH, OP_BEQ, '1, '1, '1, '1);
        send_item(KIND_REDIRECT, '1, '1, '1, '1, 16'hFFFF);
        send_item(KIND_FETCH, 6'h3F, '0, '0, '0, '0);
        send_item(KIND_REDIRECT, '0, '0, '0, '0, 16'h0000);

        // Not-taken mode with a program length of 65535: every opcode kind once.
        reconfigure(65535, 1'b0);
        send_item(KIND_FETCH, 6'h00, '0, '0, '0, '0);
        send_item(KIND_FETCH, 6'h3F, '1, '1, '1, '1);
        for (k = 0; k < 8; k++)
            send_item(KIND_FETCH, OP_BEQ + OPCODE_BITS'(k), 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0001_2340 + k, '0);

        // Taken mode: jumps, then JR holding the pc, then the top of the address space.
        reconfigure(65535, 1'b1);
        for (k = 0; k < 7; k++)
            send_item(KIND_FETCH, OP_BEQ + OPCODE_BITS'(k), 32'h8000_0000 + 3 * k,
                      32'h7FFF_0000 + 5 + k, 32'hFFFF_0000 + 40 + k, '0);
        send_item(KIND_FETCH, OP_JR, '1, '1, '1, '0);
        send_item(KIND_FETCH, OP_JR, '0, '0, '0, '0);
        send_item(KIND_REDIRECT, OP_JR, '0, '0, '0, 16'hFFFE);
        send_item(KIND_FETCH, 6'h21, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0F0F_0F0F, '0);
        send_item(KIND_FETCH, OP_J, '0, '0, '0, '0);

        // Random phases over a range of settings.
        for (k = 0; k < 7; k++)
        begin
            case (k)
                0: begin plen = 64;    taken = 1'b0; count = 350; end
                1: begin plen = 64;    taken = 1'b1; count = 350; end
                2: begin plen = 65535; taken = 1'b1; count = 300; end
                3: begin plen = 0;     taken = 1'b0; count = 40;  end
                4: begin plen = $urandom_range(300, 1); taken = 1'b1; count = 350; end
                5: begin plen = $urandom_range(300, 1); taken = 1'b0; count = 350; end
                default: begin plen = 1; taken = 1'b1; count = 300; end
            endcase
            reconfigure(plen, taken);
            steady = (k == 1);
            repeat (count) random_item();
            steady = 1'b0;
        end

        drain();
        repeat (5) @(negedge clk);

        $display("Sent %0d input transactions under %0d register settings;", sent_count,
                 setting_count);
        $display("checked %0d results, %0d of them with an instruction fetched.",
                 result_count, fetch_count);
        if (error_count == 0 && pending_count == 0)
            $display("static_predict_fetch_stage_top_test: clean");
        else
            $display("static_predict_fetch_stage_top_test: errors");
        $finish;
    end

endmodule
